### rtl/core/mean_rms_meter_accumulator_macros.svh
// Assertion macros shared by the meter checker.
`ifndef MEAN_RMS_METER_ACCUMULATOR_MACROS_SVH
`define MEAN_RMS_METER_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MRMS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("meter assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MRMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("meter assertion failed");

`endif

### rtl/core/mrms_pkg.sv
// Package: constants, types and state codes of the mean/RMS meter.
`timescale 1ns / 1ps
package mrms_pkg;

	localparam int ADC_BITS        = 12;
	localparam int SCANS_PER_GROUP = 4;
	localparam int ADC_FULL_SCALE  = 4096;
	localparam int COUNT_BITS      = 16;

	localparam int SCAN_SHIFT  = $clog2(SCANS_PER_GROUP);
	localparam int FS_SHIFT    = $clog2(ADC_FULL_SCALE);
	localparam int SCAN_CNT_W  = (SCAN_SHIFT < 1) ? 1 : SCAN_SHIFT;
	localparam int GROUP_W     = ADC_BITS + SCAN_SHIFT;
	localparam int DIFF_W      = GROUP_W + 1;
	localparam int DEV_W       = DIFF_W - SCAN_SHIFT;
	localparam int SQ_W        = 2 * DEV_W;
	localparam int SUM_W       = 30;
	localparam int SQSUM_W     = 41;
	localparam int REFSUM_W    = 31;
	localparam int VALUE_W     = 48;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 32;

	localparam int SUPPLY_SHIFT = FS_SHIFT + SCAN_SHIFT;
	localparam int MEAN_SHIFT   = FS_SHIFT + 16;
	localparam int RMS_SHIFT    = FS_SHIFT + 32;

	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 96;
	localparam int DIV_D_W = COUNT_BITS + MEAN_SHIFT;
	localparam int SQRT_W  = 64;

	localparam logic [31:0] RST_REFERENCE_VOLTS   = 32'd81895;
	localparam logic [31:0] RST_GAIN_VOLTAGE_LOW  = 32'd330868;
	localparam logic [31:0] RST_GAIN_VOLTAGE_HIGH = 32'd3342336;
	localparam logic [31:0] RST_GAIN_CURRENT_LOW  = 32'd6750;
	localparam logic [31:0] RST_GAIN_CURRENT_HIGH = 32'd64225;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEASURE_RMS        = 8'd0,
		REG_VOLTAGE_HIGH_RANGE = 8'd1,
		REG_CURRENT_HIGH_RANGE = 8'd2,
		REG_REFERENCE_VOLTS    = 8'd3,
		REG_GAIN_VOLTAGE_LOW   = 8'd4,
		REG_GAIN_VOLTAGE_HIGH  = 8'd5,
		REG_GAIN_CURRENT_LOW   = 8'd6,
		REG_GAIN_CURRENT_HIGH  = 8'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUP_MUL,
		ST_SUP_DIV,
		ST_GAIN_MUL,
		ST_MEAN_MUL,
		ST_MEAN_DIV,
		ST_RMS_DIV,
		ST_RMS_SQRT,
		ST_RMS_MUL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]    voltage_sum;
		logic signed [SUM_W-1:0]    current_sum;
		logic        [SQSUM_W-1:0]  voltage_square_sum;
		logic        [SQSUM_W-1:0]  current_square_sum;
		logic        [REFSUM_W-1:0] reference_sum;
		logic        [COUNT_BITS-1:0] group_count;
		logic                       saturated;
	} acc_t;

endpackage

### rtl/core/mrms_ifs.sv
// Interfaces: scan word, result word and configuration write channels.
`timescale 1ns / 1ps
interface mrms_scan_if import mrms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                op;
	logic [ADC_BITS-1:0] current_raw;
	logic [ADC_BITS-1:0] voltage_raw;
	logic [ADC_BITS-1:0] reference_raw;
	modport source (output valid, op, current_raw, voltage_raw, reference_raw, input ready);
	modport sink (input valid, op, current_raw, voltage_raw, reference_raw, output ready);
endinterface

interface mrms_result_if import mrms_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      valid_res;
	logic                      is_rms;
	logic [15:0]               sample_count;
	logic                      count_saturated;
	logic [31:0]               supply_volts;
	logic signed [VALUE_W-1:0] voltage_value;
	logic signed [VALUE_W-1:0] current_value;
	modport source (output valid, valid_res, is_rms, sample_count, count_saturated,
		supply_volts, voltage_value, current_value, input ready);
	modport sink (input valid, valid_res, is_rms, sample_count, count_saturated,
		supply_volts, voltage_value, current_value, output ready);
endinterface

interface mrms_cfg_if import mrms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/mrms_accum.sv
// Scan accumulator: four-scan groups, offset removal, running sums and squares.
`timescale 1ns / 1ps
module mrms_accum import mrms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                scan_en,
	input  logic                clear,
	input  logic [ADC_BITS-1:0] current_raw,
	input  logic [ADC_BITS-1:0] voltage_raw,
	input  logic [ADC_BITS-1:0] reference_raw,
	output logic                busy,
	output acc_t                acc
);

	logic [SCAN_CNT_W-1:0] scan_cnt_q;
	logic [GROUP_W-1:0]    grp_v_q, grp_i_q, grp_r_q;
	logic [GROUP_W-1:0]    grp_v_n, grp_i_n, grp_r_n;
	logic [GROUP_W-1:0]    grp_v_s1, grp_i_s1, grp_r_s1;
	logic                  close_s1;
	acc_t                  acc_q;
	logic                  last;
	logic signed [DIFF_W-1:0] diff_v, diff_i, adj_v, adj_i;
	logic signed [DEV_W-1:0]  dev_v, dev_i;
	logic signed [SQ_W-1:0]   sq_v, sq_i;

	assign grp_v_n = grp_v_q + GROUP_W'(voltage_raw);
	assign grp_i_n = grp_i_q + GROUP_W'(current_raw);
	assign grp_r_n = grp_r_q + GROUP_W'(reference_raw);
	assign last    = (scan_cnt_q == SCAN_CNT_W'(SCANS_PER_GROUP - 1));

	// subtract the reference group from the registered group, then divide by group size, truncating toward zero
	assign diff_v = $signed({1'b0, grp_v_s1}) - $signed({1'b0, grp_r_s1});
	assign diff_i = $signed({1'b0, grp_i_s1}) - $signed({1'b0, grp_r_s1});
	assign adj_v  = diff_v + (diff_v[DIFF_W-1] ? DIFF_W'(SCANS_PER_GROUP - 1) : '0);
	assign adj_i  = diff_i + (diff_i[DIFF_W-1] ? DIFF_W'(SCANS_PER_GROUP - 1) : '0);
	assign dev_v  = adj_v[DIFF_W-1:SCAN_SHIFT];
	assign dev_i  = adj_i[DIFF_W-1:SCAN_SHIFT];
	assign sq_v   = dev_v * dev_v;
	assign sq_i   = dev_i * dev_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			grp_v_q    <= '0;
			grp_i_q    <= '0;
			grp_r_q    <= '0;
			grp_v_s1   <= '0;
			grp_i_s1   <= '0;
			grp_r_s1   <= '0;
			close_s1   <= 1'b0;
			acc_q      <= '0;
		end else if (clear) begin
			scan_cnt_q <= '0;
			grp_v_q    <= '0;
			grp_i_q    <= '0;
			grp_r_q    <= '0;
			close_s1   <= 1'b0;
			acc_q      <= '0;
		end else begin
			close_s1 <= 1'b0;
			if (close_s1) begin
				if (acc_q.group_count == {COUNT_BITS{1'b1}}) begin
					// drop the whole group once the counter is full
					acc_q.saturated <= 1'b1;
				end else begin
					acc_q.voltage_sum        <= acc_q.voltage_sum + SUM_W'(dev_v);
					acc_q.current_sum        <= acc_q.current_sum + SUM_W'(dev_i);
					acc_q.voltage_square_sum <= acc_q.voltage_square_sum
						+ SQSUM_W'($unsigned(sq_v));
					acc_q.current_square_sum <= acc_q.current_square_sum
						+ SQSUM_W'($unsigned(sq_i));
					acc_q.reference_sum      <= acc_q.reference_sum + REFSUM_W'(grp_r_s1);
					acc_q.group_count        <= acc_q.group_count + 1'b1;
				end
			end
			if (scan_en) begin
				if (last) begin
					scan_cnt_q <= '0;
					grp_v_q    <= '0;
					grp_i_q    <= '0;
					grp_r_q    <= '0;
					grp_v_s1   <= grp_v_n;
					grp_i_s1   <= grp_i_n;
					grp_r_s1   <= grp_r_n;
					close_s1   <= 1'b1;
				end else begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					grp_v_q    <= grp_v_n;
					grp_i_q    <= grp_i_n;
					grp_r_q    <= grp_r_n;
				end
			end
		end
	end

	assign busy = close_s1;
	assign acc  = acc_q;

endmodule

### rtl/core/mrms_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mrms_smul import mrms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               busy,
	output logic [MUL_P_W-1:0] product
);

	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [MUL_P_W-1:0] acc_q, a_sh_q;
	logic [MUL_B_W-1:0] b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MUL_B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			a_sh_q <= MUL_P_W'(a);
			b_q    <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= {a_sh_q[MUL_P_W-2:0], 1'b0};
			b_q    <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

### rtl/core/mrms_sdiv.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mrms_sdiv import mrms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic               busy,
	output logic [DIV_N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [DIV_N_W-1:0] num_q;
	logic [DIV_D_W-1:0] den_q, rem_q;
	logic [DIV_D_W:0]   trial, diff;
	logic               ge;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;

	assign trial = {rem_q, num_q[DIV_N_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			num_q <= {num_q[DIV_N_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

endmodule

### rtl/core/mrms_sqrt.sv
// Integer square root, one root bit (two radicand bits) per cycle.
`timescale 1ns / 1ps
module mrms_sqrt import mrms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQRT_W-1:0]   radicand,
	output logic                busy,
	output logic [SQRT_W/2-1:0] root
);

	localparam int ROOT_W = SQRT_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [SQRT_W-1:0] v_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W+1:0]  r, trial, diff;
	logic              ge;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	assign r     = {rem_q, v_q[SQRT_W-1:SQRT_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = (r >= trial);
	assign diff  = r - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[REM_W-1:0] : r[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			v_q    <= {v_q[SQRT_W-3:0], 2'b00};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

### rtl/core/mean_rms_meter_accumulator.sv
// Top level: mean/RMS meter accumulator with configuration and report sequencer.
`timescale 1ns / 1ps
// Scan words (op = 0) are taken one per clock whenever the block is idle,
// except for the clock right after the word that completes a four-scan group:
// intake pauses there while the group is folded into the running sums. Each
// completed group adds its reference-corrected deviation to the running sums
// and sums of squares. A report word (op = 1) snapshots and clears the sums,
// then a sequencer computes the supply voltage and both channel values on
// three shared bit-serial units: a shift-add multiplier, a restoring divider
// and a square-root unit; each step launches its unit once and completes when
// the unit drops busy. An invalid report (no groups or zero reference sum)
// skips the units and goes straight to the output register. No scan is taken
// while a report is being computed. The finished result sits in an output
// register, so scans are accepted again while it waits to be taken; a second
// report waits for the output register only at its very end. Configuration
// writes are always ready and take effect the next clock; write them only
// while idle.
module mean_rms_meter_accumulator import mrms_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mrms_scan_if.sink     scan,
	mrms_result_if.source result,
	mrms_cfg_if.sink      cfg
);

	// configuration registers
	logic        measure_rms_q, voltage_high_range_q, current_high_range_q;
	logic [31:0] reference_volts_q, gain_voltage_low_q, gain_voltage_high_q;
	logic [31:0] gain_current_low_q, gain_current_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_rms_q        <= 1'b0;
			voltage_high_range_q <= 1'b0;
			current_high_range_q <= 1'b0;
			reference_volts_q    <= RST_REFERENCE_VOLTS;
			gain_voltage_low_q   <= RST_GAIN_VOLTAGE_LOW;
			gain_voltage_high_q  <= RST_GAIN_VOLTAGE_HIGH;
			gain_current_low_q   <= RST_GAIN_CURRENT_LOW;
			gain_current_high_q  <= RST_GAIN_CURRENT_HIGH;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MEASURE_RMS:        measure_rms_q        <= cfg.data[0];
				REG_VOLTAGE_HIGH_RANGE: voltage_high_range_q <= cfg.data[0];
				REG_CURRENT_HIGH_RANGE: current_high_range_q <= cfg.data[0];
				REG_REFERENCE_VOLTS:    reference_volts_q    <= cfg.data;
				REG_GAIN_VOLTAGE_LOW:   gain_voltage_low_q   <= cfg.data;
				REG_GAIN_VOLTAGE_HIGH:  gain_voltage_high_q  <= cfg.data;
				REG_GAIN_CURRENT_LOW:   gain_current_low_q   <= cfg.data;
				REG_GAIN_CURRENT_HIGH:  gain_current_high_q  <= cfg.data;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// input handshake; hold intake outside idle and while a completed group is being folded in
	seq_state_t state_q, state_n;
	logic       scan_acc, report_acc, acc_busy;
	acc_t       acc;

	assign scan.ready = (state_q == ST_IDLE) && !acc_busy;
	assign scan_acc   = scan.valid && scan.ready && !scan.op;
	assign report_acc = scan.valid && scan.ready && scan.op;

	mrms_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_en       (scan_acc),
		.clear         (report_acc),
		.current_raw   (scan.current_raw),
		.voltage_raw   (scan.voltage_raw),
		.reference_raw (scan.reference_raw),
		.busy          (acc_busy),
		.acc           (acc)
	);

	// report snapshot and working registers
	acc_t                snap_q;
	logic                valid_q, is_rms_q, ch_q, launched_q;
	logic [31:0]         supply_q;
	logic [MUL_A_W-1:0]  factor_q;
	logic [VALUE_W-1:0]  vval_q, ival_q;
	logic                report_valid;

	assign report_valid = (acc.group_count != '0) && (acc.reference_sum != '0);

	// shared serial units
	logic               mul_start, div_start, sqrt_start;
	logic               mul_busy, div_busy, sqrt_busy;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [DIV_N_W-1:0] div_n, div_q;
	logic [DIV_D_W-1:0] div_d;
	logic [SQRT_W-1:0]  sqrt_v;
	logic [SQRT_W/2-1:0] sqrt_r;

	mrms_smul u_smul (
		.clk (clk), .arst_n (arst_n), .start (mul_start),
		.a (mul_a), .b (mul_b), .busy (mul_busy), .product (mul_p)
	);

	mrms_sdiv u_sdiv (
		.clk (clk), .arst_n (arst_n), .start (div_start),
		.num (div_n), .den (div_d), .busy (div_busy), .quotient (div_q)
	);

	mrms_sqrt u_sqrt (
		.clk (clk), .arst_n (arst_n), .start (sqrt_start),
		.radicand (sqrt_v), .busy (sqrt_busy), .root (sqrt_r)
	);

	// channel selection: ch_q = 0 voltage, 1 current
	logic signed [SUM_W-1:0] ch_sum;
	logic [SUM_W-1:0]        ch_mag;
	logic [SQSUM_W-1:0]      ch_sq;
	logic [31:0]             ch_gain;
	logic                    ch_neg;

	assign ch_sum  = ch_q ? snap_q.current_sum : snap_q.voltage_sum;
	assign ch_sq   = ch_q ? snap_q.current_square_sum : snap_q.voltage_square_sum;
	assign ch_neg  = ch_sum[SUM_W-1];
	assign ch_mag  = ch_neg ? SUM_W'(-ch_sum) : SUM_W'(ch_sum);
	assign ch_gain = ch_q ? (current_high_range_q ? gain_current_high_q : gain_current_low_q)
		: (voltage_high_range_q ? gain_voltage_high_q : gain_voltage_low_q);

	// operand routing per step
	always_comb begin
		mul_a  = factor_q;
		mul_b  = MUL_B_W'(ch_mag);
		div_n  = mul_p;
		div_d  = {snap_q.group_count, {MEAN_SHIFT{1'b0}}};
		sqrt_v = (|div_q[DIV_N_W-1:SQRT_W]) ? {SQRT_W{1'b1}} : div_q[SQRT_W-1:0];
		unique case (state_q)
			ST_SUP_MUL: begin
				mul_a = MUL_A_W'(reference_volts_q);
				mul_b = MUL_B_W'(snap_q.group_count);
			end
			ST_SUP_DIV: begin
				div_n = {mul_p[DIV_N_W-SUPPLY_SHIFT-1:0], {SUPPLY_SHIFT{1'b0}}};
				div_d = DIV_D_W'(snap_q.reference_sum);
			end
			ST_GAIN_MUL: begin
				mul_a = MUL_A_W'(ch_gain);
				mul_b = MUL_B_W'(supply_q);
			end
			ST_RMS_DIV: begin
				div_n = {(DIV_N_W - SQSUM_W - 32)'(0), ch_sq, 32'd0};
				div_d = DIV_D_W'(snap_q.group_count);
			end
			ST_RMS_MUL: begin
				mul_b = MUL_B_W'(sqrt_r);
			end
			default: ;
		endcase
	end

	// a step launches its unit once, then completes when the unit drops busy
	logic op_state, unit_busy, step_done;

	always_comb begin
		op_state  = 1'b1;
		unit_busy = mul_busy;
		unique case (state_q)
			ST_SUP_DIV, ST_MEAN_DIV, ST_RMS_DIV: unit_busy = div_busy;
			ST_RMS_SQRT:                         unit_busy = sqrt_busy;
			ST_SUP_MUL, ST_GAIN_MUL, ST_MEAN_MUL, ST_RMS_MUL: unit_busy = mul_busy;
			default:                             op_state  = 1'b0;
		endcase
	end

	assign step_done  = op_state && launched_q && !unit_busy;
	assign mul_start  = op_state && !launched_q && (state_q == ST_SUP_MUL
		|| state_q == ST_GAIN_MUL || state_q == ST_MEAN_MUL || state_q == ST_RMS_MUL);
	assign div_start  = op_state && !launched_q && (state_q == ST_SUP_DIV
		|| state_q == ST_MEAN_DIV || state_q == ST_RMS_DIV);
	assign sqrt_start = op_state && !launched_q && (state_q == ST_RMS_SQRT);

	// output slot
	logic res_valid_q, out_free, out_load;

	assign out_free = !res_valid_q || result.ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (report_acc) state_n = report_valid ? ST_SUP_MUL : ST_DONE;
			end
			ST_SUP_MUL: begin
				if (step_done) state_n = ST_SUP_DIV;
			end
			ST_SUP_DIV: begin
				if (step_done) state_n = ST_GAIN_MUL;
			end
			ST_GAIN_MUL: begin
				if (step_done) state_n = is_rms_q ? ST_RMS_DIV : ST_MEAN_MUL;
			end
			ST_MEAN_MUL: begin
				if (step_done) state_n = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				if (step_done) state_n = ch_q ? ST_DONE : ST_GAIN_MUL;
			end
			ST_RMS_DIV: begin
				if (step_done) state_n = ST_RMS_SQRT;
			end
			ST_RMS_SQRT: begin
				if (step_done) state_n = ST_RMS_MUL;
			end
			ST_RMS_MUL: begin
				if (step_done) state_n = ch_q ? ST_DONE : ST_GAIN_MUL;
			end
			ST_DONE: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// saturate a quotient or product magnitude into the signed 48-bit range
	function automatic logic [VALUE_W-1:0] sat48(input logic [MUL_P_W-1:0] q, input logic neg);
		logic [VALUE_W-1:0] m;
		logic               big;
		begin
			if (neg) begin
				big = (|q[MUL_P_W-1:VALUE_W]) || (q[VALUE_W-1] && (|q[VALUE_W-2:0]));
				m   = big ? {1'b1, {(VALUE_W-1){1'b0}}} : q[VALUE_W-1:0];
				sat48 = -m;
			end else begin
				big   = |q[MUL_P_W-1:VALUE_W-1];
				sat48 = big ? {1'b0, {(VALUE_W-1){1'b1}}} : q[VALUE_W-1:0];
			end
		end
	endfunction

	logic [VALUE_W-1:0] step_value;

	always_comb begin
		if (state_q == ST_MEAN_DIV) begin
			step_value = sat48(div_q, ch_neg);
		end else begin
			step_value = sat48(MUL_P_W'(mul_p[MUL_P_W-1:RMS_SHIFT]), 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launched_q <= 1'b0;
			ch_q       <= 1'b0;
		end else begin
			if (step_done) begin
				launched_q <= 1'b0;
			end else if (mul_start || div_start || sqrt_start) begin
				launched_q <= 1'b1;
			end
			if (report_acc) begin
				ch_q <= 1'b0;
			end else if (step_done && (state_q == ST_MEAN_DIV || state_q == ST_RMS_MUL)) begin
				ch_q <= 1'b1;
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (report_acc) begin
			snap_q   <= acc;
			valid_q  <= report_valid;
			is_rms_q <= measure_rms_q;
			supply_q <= '0;
			vval_q   <= '0;
			ival_q   <= '0;
		end
		if (step_done) begin
			unique case (state_q)
				ST_SUP_DIV: begin
					supply_q <= (|div_q[DIV_N_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
				end
				ST_GAIN_MUL: begin
					factor_q <= mul_p[MUL_A_W-1:0];
				end
				ST_MEAN_DIV, ST_RMS_MUL: begin
					if (ch_q) ival_q <= step_value;
					else      vval_q <= step_value;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.valid_res       <= valid_q;
			result.is_rms          <= is_rms_q;
			result.sample_count    <= 16'(snap_q.group_count);
			result.count_saturated <= snap_q.saturated;
			result.supply_volts    <= supply_q;
			result.voltage_value   <= vval_q;
			result.current_value   <= ival_q;
		end
	end

	assign result.valid = res_valid_q;

endmodule

### rtl/core/mrms_checker.sv
// Port checker for the meter accumulator, with its bind.
`timescale 1ns / 1ps
`include "mean_rms_meter_accumulator_macros.svh"
module mrms_checker import mrms_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               scan_valid,
	input logic               scan_ready,
	input logic               scan_op,
	input logic               res_valid,
	input logic               res_ready,
	input logic               valid_res,
	input logic [15:0]        sample_count,
	input logic [31:0]        supply_volts,
	input logic [VALUE_W-1:0] voltage_value,
	input logic [VALUE_W-1:0] current_value
);

	// a report word stops intake for at least the next cycle
	`MRMS_ASSERT_NEXT(a_report_stalls, scan_valid && scan_ready && scan_op, !scan_ready)

	// an invalid report carries zero measurements
	`MRMS_ASSERT_IMPL(a_invalid_zero, res_valid && !valid_res,
		supply_volts == '0 && voltage_value == '0 && current_value == '0)

	// a valid report has at least one group behind it
	`MRMS_ASSERT_IMPL(a_valid_count, res_valid && valid_res, sample_count != '0)

	// a stalled result word holds
	`MRMS_ASSERT_NEXT(a_result_holds, res_valid && !res_ready,
		res_valid && $stable(supply_volts) && $stable(voltage_value))

endmodule

bind mean_rms_meter_accumulator mrms_checker u_mrms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.scan_valid    (scan.valid),
	.scan_ready    (scan.ready),
	.scan_op       (scan.op),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.valid_res     (result.valid_res),
	.sample_count  (result.sample_count),
	.supply_volts  (result.supply_volts),
	.voltage_value (result.voltage_value),
	.current_value (result.current_value)
);
